// ===== rtl/wavetable_voice_interpolator_unit_macros.svh =====
// Assertion macros for the wavetable voice interpolator.
// Included by the top level; no other dependencies.
`ifndef WAVETABLE_VOICE_INTERPOLATOR_UNIT_MACROS_SVH
`define WAVETABLE_VOICE_INTERPOLATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define WVI_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("wvi same-cycle check failed");
`define WVI_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("wvi next-cycle check failed");
`else
`define WVI_ASSERT_IMP(label, clock, reset, ante, cons)
`define WVI_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

// ===== rtl/wvi_pkg.sv =====
// Shared types and constants for the wavetable voice interpolator.
// Used by wvi_regs, wvi_ctrl, wvi_dpath and the top level; depends on nothing.
package wvi_pkg;

  localparam int unsigned WAVE_DEPTH_DEFAULT = 65536;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned FRAC_BITS = 9;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [2:0] REG_LOOP_START = 3'd0;
  localparam logic [2:0] REG_LOOP_END   = 3'd1;
  localparam logic [2:0] REG_LOOP_LEN   = 3'd2;
  localparam logic [2:0] REG_LOOPING    = 3'd3;
  localparam logic [2:0] REG_BIDIR      = 3'd4;

  // ceil(2^32 / 25): floor(m * 256 / 100) equals (m * RECIP_25) >> 26 for m below 2^23.
  localparam logic [27:0] RECIP_25 = 28'd171798692;
  localparam int unsigned RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_V1,
    ST_INTERP,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } wvi_state_t;

  typedef struct packed {
    logic [24:0] loop_start;
    logic [24:0] loop_end;
    logic [24:0] loop_length;
    logic        looping_on;
    logic        bidirectional_on;
  } wvi_cfg_t;

  typedef struct packed {
    logic wr_mem;
    logic start;
    logic tick_load;
    logic rd_next;
    logic v1_load;
    logic interp_en;
    logic scale_en;
    logic div_en;
    logic finish;
  } wvi_cmd_t;

endpackage

// ===== rtl/wvi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wvi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wvi_regs.sv =====
// Configuration registers of the wavetable voice behind an APB-style port.
// Depends on wvi_pkg.
module wvi_regs
  import wvi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output wvi_cfg_t           cfg
);

  logic [2:0] reg_index;
  logic       wr;

  assign reg_index = paddr[4:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_start       <= '0;
      cfg.loop_end         <= '1;
      cfg.loop_length      <= '0;
      cfg.looping_on       <= 1'b0;
      cfg.bidirectional_on <= 1'b0;
    end else if (wr) begin
      case (reg_index)
        REG_LOOP_START: cfg.loop_start       <= pwdata[24:0];
        REG_LOOP_END:   cfg.loop_end         <= pwdata[24:0];
        REG_LOOP_LEN:   cfg.loop_length      <= pwdata[24:0];
        REG_LOOPING:    cfg.looping_on       <= pwdata[0];
        REG_BIDIR:      cfg.bidirectional_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LOOP_START: prdata = {7'd0, cfg.loop_start};
      REG_LOOP_END:   prdata = {7'd0, cfg.loop_end};
      REG_LOOP_LEN:   prdata = {7'd0, cfg.loop_length};
      REG_LOOPING:    prdata = {31'd0, cfg.looping_on};
      REG_BIDIR:      prdata = {31'd0, cfg.bidirectional_on};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/wvi_ctrl.sv =====
// Sequencer of the wavetable voice: takes input words and steps a tick
// through the datapath. Depends on wvi_pkg.
module wvi_ctrl
  import wvi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic [1:0] mode,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  output wvi_cmd_t   cmd
);

  wvi_state_t state;
  wvi_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.wr_mem = (mode == MODE_WRITE);
          cmd.start = (mode == MODE_START);
          if (mode == MODE_TICK) begin
            cmd.tick_load = 1'b1;
            state_next = ST_V1;
          end
        end
      end
      ST_V1: begin
        cmd.rd_next = 1'b1;
        cmd.v1_load = 1'b1;
        state_next = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp_en = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_en = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/wvi_dpath.sv =====
// Datapath of the wavetable voice: sample memory, interpolation, volume
// scaling and position update. Depends on wvi_pkg and wvi_ram.
module wvi_dpath
  import wvi_pkg::*;
#(
  parameter int unsigned WAVE_DEPTH = WAVE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  wvi_cmd_t           cmd,
  input  wvi_cfg_t           cfg,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample,
  input  logic [24:0]        position,
  input  logic signed [25:0] step_in,
  input  logic               start_backward,
  input  logic [7:0]         left_vol,
  input  logic [7:0]         right_vol,
  input  logic [7:0]         rear_left_vol,
  input  logic [7:0]         rear_right_vol,
  output logic signed [25:0] front_left_out,
  output logic signed [25:0] front_right_out,
  output logic signed [25:0] rear_left_out,
  output logic signed [25:0] rear_right_out
);

  localparam int unsigned AW = $clog2(WAVE_DEPTH);

  logic signed [25:0] play_position;
  logic signed [25:0] play_step;
  logic               going_backward;

  logic [AW-1:0]      waddr;
  logic [AW-1:0]      addr0;
  logic [AW-1:0]      addr1;
  logic [AW-1:0]      raddr;
  logic [15:0]        rdata;
  logic [24:0]        ix_ext;
  logic [24:0]        waddr_ext;

  logic [3:0][7:0]    vol;
  logic signed [15:0] v1;
  logic signed [16:0] diff;
  logic signed [26:0] frac_s;
  logic signed [26:0] interp_next;
  logic signed [26:0] interp;

  logic signed [17:0] acc;
  logic [17:0]        acc_abs;
  logic [3:0][22:0]   mag;
  logic [3:0][24:0]   mag_full;
  logic               neg;
  logic [3:0][50:0]   recip_prod;
  logic [3:0][24:0]   quot;
  logic [3:0][25:0]   scaled;

  logic signed [27:0] sum;
  logic signed [27:0] loop_end_s;
  logic signed [27:0] loop_start_s;
  logic signed [27:0] loop_len_s;
  logic               wrap_end;
  logic               wrap_start;
  logic signed [27:0] p1_next;
  logic signed [27:0] p1;
  logic signed [25:0] step1_next;
  logic signed [25:0] step1;
  logic               back1_next;
  logic               back1;
  logic signed [27:0] p2_next;
  logic signed [27:0] p2;
  logic signed [25:0] step2_next;
  logic signed [25:0] step2;
  logic               back2_next;
  logic               back2;

  assign ix_ext = {{8{play_position[25]}}, play_position[25:FRAC_BITS]};
  assign addr0 = ix_ext[AW-1:0];
  assign addr1 = addr0 + AW'(1);
  assign raddr = cmd.rd_next ? addr1 : addr0;
  assign waddr_ext = {9'd0, address};
  assign waddr = waddr_ext[AW-1:0];

  wvi_ram #(
    .WIDTH(16),
    .DEPTH(WAVE_DEPTH)
  ) u_wave_ram (
    .clk  (clk),
    .we   (cmd.wr_mem),
    .waddr(waddr),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign diff = $signed({rdata[15], rdata}) - $signed({v1[15], v1});
  assign frac_s = $signed({18'd0, play_position[FRAC_BITS-1:0]});
  assign interp_next = diff * frac_s;

  assign acc = $signed({{2{v1[15]}}, v1}) + $signed(interp[26:FRAC_BITS]);
  assign acc_abs = acc[17] ? 18'(-acc) : acc;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_full[i] = 25'(acc_abs[16:0]) * 25'(vol[i]);
      recip_prod[i] = 51'(mag[i]) * 51'(RECIP_25);
      scaled[i] = neg ? 26'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
    end
  end

  assign loop_end_s = $signed({3'd0, cfg.loop_end});
  assign loop_start_s = $signed({3'd0, cfg.loop_start});
  assign loop_len_s = $signed({3'd0, cfg.loop_length});

  always_comb begin
    wrap_end = (sum > loop_end_s);
    p1_next = sum;
    step1_next = play_step;
    back1_next = going_backward;
    if (wrap_end) begin
      if (cfg.looping_on) begin
        if (cfg.bidirectional_on) begin
          back1_next = !going_backward;
          step1_next = -play_step;
        end else begin
          p1_next = sum - loop_len_s;
        end
      end else begin
        p1_next = 28'(play_position);
      end
    end
  end

  always_comb begin
    wrap_start = back1 && (p1 < loop_start_s);
    p2_next = p1;
    step2_next = step1;
    back2_next = back1;
    if (wrap_start) begin
      if (cfg.bidirectional_on) begin
        back2_next = !back1;
        step2_next = -step1;
      end else begin
        p2_next = p1 + loop_len_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      play_step <= '0;
      going_backward <= 1'b0;
    end else if (cmd.start) begin
      play_position <= $signed({1'b0, position});
      play_step <= step_in;
      going_backward <= start_backward;
    end else if (cmd.finish) begin
      play_position <= p2[25:0];
      play_step <= step2;
      going_backward <= back2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      vol <= {rear_right_vol, rear_left_vol, right_vol, left_vol};
    end
    if (cmd.v1_load) begin
      v1 <= rdata;
      sum <= 28'(play_position) + 28'(play_step);
    end
    if (cmd.interp_en) begin
      interp <= interp_next;
      p1 <= p1_next;
      step1 <= step1_next;
      back1 <= back1_next;
    end
    if (cmd.scale_en) begin
      for (int i = 0; i < 4; i++) begin
        mag[i] <= mag_full[i][22:0];
      end
      neg <= acc[17];
      p2 <= p2_next;
      step2 <= step2_next;
      back2 <= back2_next;
    end
    if (cmd.div_en) begin
      for (int i = 0; i < 4; i++) begin
        quot[i] <= recip_prod[i][50:RECIP_SHIFT];
      end
    end
    if (cmd.finish) begin
      front_left_out <= scaled[0];
      front_right_out <= scaled[1];
      rear_left_out <= scaled[2];
      rear_right_out <= scaled[3];
    end
  end

endmodule

// ===== rtl/wavetable_voice_interpolator_unit.sv =====
// Top level of the wavetable voice interpolator.
// Depends on wvi_pkg, wvi_regs, wvi_ctrl, wvi_dpath and the macro header.
//
// One wavetable voice with a sample memory of WAVE_DEPTH signed 16-bit
// entries (a power of two; addresses wrap at the depth). A write word or a
// start word leaves the block idle, so the next word can follow at once. A
// tick word holds item_ready low through ST_V1 to ST_FINISH, for two reads
// of the one-read-port sample memory and the interpolation, volume and
// divide-by-100 multiply stages. The result is loaded into the output
// register on leaving ST_FINISH, which waits while an earlier result is
// unaccepted; then a new word is taken. The sample memory is not cleared
// at reset: entries must be written before a tick reads them. The user must
// write configuration while the block is idle, which it does not enforce.
`include "wavetable_voice_interpolator_unit_macros.svh"

module wavetable_voice_interpolator_unit
  import wvi_pkg::*;
#(
  parameter int unsigned WAVE_DEPTH = WAVE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         mode,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample,
  input  logic [24:0]        position,
  input  logic signed [25:0] step_in,
  input  logic               start_backward,
  input  logic [7:0]         left_vol,
  input  logic [7:0]         right_vol,
  input  logic [7:0]         rear_left_vol,
  input  logic [7:0]         rear_right_vol,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [25:0] front_left_out,
  output logic signed [25:0] front_right_out,
  output logic signed [25:0] rear_left_out,
  output logic signed [25:0] rear_right_out
);

  wvi_cfg_t cfg;
  wvi_cmd_t cmd;

  wvi_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  wvi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .mode        (mode),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cmd         (cmd)
  );

  wvi_dpath #(
    .WAVE_DEPTH(WAVE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .address        (address),
    .sample         (sample),
    .position       (position),
    .step_in        (step_in),
    .start_backward (start_backward),
    .left_vol       (left_vol),
    .right_vol      (right_vol),
    .rear_left_vol  (rear_left_vol),
    .rear_right_vol (rear_right_vol),
    .front_left_out (front_left_out),
    .front_right_out(front_right_out),
    .rear_left_out  (rear_left_out),
    .rear_right_out (rear_right_out)
  );

  `WVI_ASSERT_NEXT(a_tick_busy, clk, rst, item_valid && item_ready && mode == MODE_TICK, !item_ready)
  `WVI_ASSERT_NEXT(a_short_word, clk, rst, item_valid && item_ready && mode != MODE_TICK, item_ready)
  `WVI_ASSERT_IMP(a_result_from_tick, clk, rst, $rose(result_valid), $past(!item_ready))

endmodule
